FILE: rtl/euclidean_distance_f32_core_defines.svh
// Assertion macros shared by the checker of the distance core.
// No dependencies.
`ifndef EUCLIDEAN_DISTANCE_F32_CORE_DEFINES_SVH
`define EUCLIDEAN_DISTANCE_F32_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define ED_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication checked outside reset.
`define ED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

FILE: rtl/edf32_pkg.sv
// Package of the distance core: float helpers, state encoding, queue entry type.
// No dependencies.
package edf32_pkg;
    localparam int unsigned QueueDepth = 2;
    localparam logic [31:0] PosInf = 32'h7F800000;
    localparam logic [31:0] PosZero = 32'h00000000;

    localparam logic [1:0] OpAdd = 2'd0;
    localparam logic [1:0] OpMul = 2'd1;
    localparam logic [1:0] OpSqrt = 2'd2;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic        no_element;
        logic        last;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SUB, ST_MUL, ST_ADD, ST_SQRT, ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE, PH_PREP, PH_WORK, PH_ROUND
    } fpu_phase_t;

    function automatic logic not_finite(input logic [31:0] x);
        return x[30:23] == 8'hFF;
    endfunction
endpackage

FILE: rtl/edf32_fpu.sv
// Single float operation unit: add, multiply, square root (iterative).
// Depends on edf32_pkg.
module edf32_fpu (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  op,
    input  logic [31:0] x,
    input  logic [31:0] y,
    output logic        done,
    output logic [31:0] result
);
    import edf32_pkg::*;

    // Phases: idle, prepare, work (sqrt iterations), round.
    fpu_phase_t  phase_reg, phase_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [1:0]  op_reg, op_next;
    logic        sign_reg, sign_next;
    logic signed [11:0] e_reg, e_next;
    logic [63:0] sig_reg, sig_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] res_reg, res_next;
    logic [31:0] out_reg, out_next;
    logic        done_reg, done_next;

    logic [31:0] ux, uy, bx, sy;
    logic [23:0] mx, my;
    logic signed [11:0] ex, ey;

    function automatic logic [31:0] pack_round(input logic sgn, input logic signed [11:0] e,
                                               input logic [63:0] sig);
        logic signed [11:0] p, sh, q, be;
        logic [64:0] m;
        logic [63:0] rem, half;
        p = -12'sd1;
        for (int i = 0; i < 64; i++)
            if (sig[i]) p = 12'(i);
        sh = p - 12'sd23;
        if (-12'sd149 - e > sh) sh = -12'sd149 - e;
        if (sh <= 0) begin
            m = {1'b0, sig} << (-sh);
        end else if (sh >= 64) begin
            m = (sh == 64 && sig > 64'h8000000000000000) ? 65'd1 : 65'd0;
        end else begin
            rem = sig & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 12'sd1);
            m = {1'b0, sig >> sh};
            if (rem > half || (rem == half && m[0])) m = m + 65'd1;
        end
        q = e + sh;
        if (m == 65'd1 << 24) begin
            m = m >> 1;
            q = q + 12'sd1;
        end
        if (m[23]) begin
            be = q + 12'sd150;
            if (be >= 255) return {sgn, PosInf[30:0]};
            return {sgn, be[7:0], m[22:0]};
        end
        return {sgn, 8'd0, m[22:0]};
    endfunction

    assign done = done_reg;
    assign result = out_reg;

    always_comb
    begin
        if (op_reg == OpAdd && y[30:0] > x[30:0]) begin
            bx = y;
            sy = x;
        end else begin
            bx = x;
            sy = y;
        end
        ux = {1'b0, bx[30:0]};
        uy = {1'b0, sy[30:0]};
        mx = {bx[30:23] != 0, bx[22:0]};
        my = {sy[30:23] != 0, sy[22:0]};
        ex = (bx[30:23] == 0) ? -12'sd149 : $signed({4'd0, bx[30:23]}) - 12'sd150;
        ey = (sy[30:23] == 0) ? -12'sd149 : $signed({4'd0, sy[30:23]}) - 12'sd150;
    end

    always_comb
    begin
        logic signed [11:0] diff, k, t;
        logic [63:0] mb, ms, r, s;
        int msb;
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        op_next = op_reg;
        sign_next = sign_reg;
        e_next = e_reg;
        sig_next = sig_reg;
        rem_next = rem_reg;
        res_next = res_reg;
        out_next = out_reg;
        done_next = 1'b0;
        diff = '0; k = '0; t = '0; mb = '0; ms = '0; r = '0; s = '0; msb = 0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start) begin
                    op_next = op;
                    phase_next = PH_PREP;
                end
            end
            PH_PREP:
            begin
                phase_next = PH_ROUND;
                if (op_reg == OpAdd) begin
                    if (ux == 0 && uy == 0) begin
                        out_next = x & y & 32'h80000000;
                        phase_next = PH_IDLE;
                        done_next = 1'b1;
                    end else if (uy == 0) begin
                        out_next = bx;
                        phase_next = PH_IDLE;
                        done_next = 1'b1;
                    end else begin
                        diff = ex - ey;
                        mb = {40'd0, mx} << 38;
                        if (diff <= 38) ms = {40'd0, my} << (12'sd38 - diff);
                        else begin
                            k = diff - 12'sd38;
                            if (k >= 64) ms = 64'd1;
                            else ms = ({40'd0, my} >> k)
                                | 64'(({40'd0, my} & ((64'd1 << k) - 64'd1)) != 0);
                        end
                        if (bx[31] == sy[31]) r = mb + ms;
                        else r = mb - ms;
                        if (r == 0) begin
                            out_next = PosZero;
                            phase_next = PH_IDLE;
                            done_next = 1'b1;
                        end
                        sign_next = bx[31];
                        e_next = ex - 12'sd38;
                        sig_next = r;
                    end
                end else if (op_reg == OpMul) begin
                    if (x[30:0] == 0 || y[30:0] == 0) begin
                        out_next = {x[31] ^ y[31], 31'd0};
                        phase_next = PH_IDLE;
                        done_next = 1'b1;
                    end
                    sign_next = x[31] ^ y[31];
                    e_next = ex + ey;
                    sig_next = {40'd0, mx} * {40'd0, my};
                end else begin
                    if (x[30:0] == 0 || not_finite(x)) begin
                        out_next = x;
                        phase_next = PH_IDLE;
                        done_next = 1'b1;
                    end else begin
                        s = {40'd0, mx};
                        e_next = ex;
                        if (ex[0]) begin
                            s = s << 1;
                            e_next = ex - 12'sd1;
                        end
                        for (int i = 0; i < 64; i++)
                            if (s[i]) msb = i;
                        t = 12'((60 - msb) & ~1);
                        rem_next = s << t;
                        e_next = e_next - t;
                        res_next = '0;
                        sign_next = 1'b0;
                        cnt_next = 6'd31;
                        phase_next = PH_WORK;
                    end
                end
            end
            PH_WORK:
            begin
                // One result bit per cycle, bit weight 4^cnt.
                s = 64'd1 << {cnt_reg, 1'b0};
                if (rem_reg >= res_reg + s) begin
                    rem_next = rem_reg - (res_reg + s);
                    res_next = (res_reg >> 1) + s;
                end else begin
                    res_next = res_reg >> 1;
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 0) begin
                    sig_next = (rem_next != 0) ? (res_next | 64'd1) : res_next;
                    e_next = e_reg >>> 1;
                    phase_next = PH_ROUND;
                end
            end
            PH_ROUND:
            begin
                out_next = pack_round(sign_reg, e_reg, sig_reg);
                done_next = 1'b1;
                phase_next = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            done_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        op_reg <= op_next;
        sign_reg <= sign_next;
        e_reg <= e_next;
        sig_reg <= sig_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end
endmodule

FILE: rtl/edf32_queue.sv
// Small request queue between the front and the back of the distance core.
// Depends on edf32_pkg.
module edf32_queue #(
    parameter int unsigned DEPTH = edf32_pkg::QueueDepth
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  edf32_pkg::item_t     push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output edf32_pkg::item_t     head
);
    import edf32_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    item_t entry_reg [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;

    assign full = cnt_reg == (AW+1)'(DEPTH);
    assign empty = cnt_reg == '0;
    assign head = entry_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop) rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) entry_reg[wr_reg] <= push_item;
    end
endmodule

FILE: rtl/edf32_back.sv
// Back end: per-request subtract, square, accumulate; square root on the last one unless an input was not finite.
// Depends on edf32_pkg and edf32_fpu.
module edf32_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  edf32_pkg::item_t q_head,
    output logic             q_pop,
    output logic             valid,
    input  logic             stall,
    output logic [31:0]      distance,
    output logic             status
);
    import edf32_pkg::*;

    state_t      state_reg, state_next;
    item_t       cur_reg, cur_next;
    logic [31:0] sum_reg, sum_next, d_reg, d_next;
    logic        bad_reg, bad_next;
    logic        ov_reg, ov_next;
    logic [31:0] dist_reg, dist_next;
    logic        stat_reg, stat_next;
    logic        go_reg, go_next;

    logic        fpu_start, fpu_done;
    logic [1:0]  fpu_op;
    logic [31:0] fpu_x, fpu_y, fpu_res;

    edf32_fpu u_fpu (
        .clk(clk), .rst_n(rst_n), .start(fpu_start), .op(fpu_op),
        .x(fpu_x), .y(fpu_y), .done(fpu_done), .result(fpu_res)
    );

    assign valid = ov_reg;
    assign distance = dist_reg;
    assign status = stat_reg;

    always_comb
    begin
        state_next = state_reg;
        cur_next = cur_reg;
        sum_next = sum_reg;
        d_next = d_reg;
        bad_next = bad_reg;
        ov_next = ov_reg && stall;
        dist_next = dist_reg;
        stat_next = stat_reg;
        go_next = 1'b0;
        q_pop = 1'b0;
        fpu_start = go_reg;
        fpu_op = OpAdd;
        fpu_x = cur_reg.a;
        fpu_y = {~cur_reg.b[31], cur_reg.b[30:0]};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    cur_next = q_head;
                    if (q_head.no_element) state_next = ST_OUT;
                    else if (not_finite(q_head.a) || not_finite(q_head.b)) begin
                        bad_next = 1'b1;
                        state_next = ST_OUT;
                    end else if (bad_reg) state_next = ST_OUT;
                    else begin
                        go_next = 1'b1;
                        state_next = ST_SUB;
                    end
                end
            end
            ST_SUB:
            begin
                if (fpu_done) begin
                    d_next = fpu_res;
                    if (not_finite(fpu_res)) begin
                        sum_next = PosInf;
                        state_next = ST_OUT;
                    end else begin
                        go_next = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                fpu_op = OpMul;
                fpu_x = d_reg;
                fpu_y = d_reg;
                if (fpu_done) begin
                    d_next = fpu_res;
                    if (not_finite(sum_reg) || not_finite(fpu_res)) begin
                        sum_next = PosInf;
                        state_next = ST_OUT;
                    end else begin
                        go_next = 1'b1;
                        state_next = ST_ADD;
                    end
                end
            end
            ST_ADD:
            begin
                fpu_x = sum_reg;
                fpu_y = d_reg;
                if (fpu_done) begin
                    sum_next = fpu_res;
                    state_next = ST_OUT;
                end
            end
            ST_SQRT:
            begin
                fpu_op = OpSqrt;
                fpu_x = sum_reg;
                fpu_y = sum_reg;
                if (fpu_done) begin
                    dist_next = fpu_res;
                    stat_next = not_finite(fpu_res);
                    ov_next = 1'b1;
                    sum_next = PosZero;
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                // A last request waits for the result register to drain.
                if (!cur_reg.last) state_next = ST_IDLE;
                else if (!ov_next) begin
                    if (bad_reg) begin
                        dist_next = PosZero;
                        stat_next = 1'b1;
                        ov_next = 1'b1;
                        sum_next = PosZero;
                        bad_next = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        go_next = 1'b1;
                        state_next = ST_SQRT;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            sum_reg <= PosZero;
            bad_reg <= 1'b0;
            ov_reg <= 1'b0;
            go_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sum_reg <= sum_next;
            bad_reg <= bad_next;
            ov_reg <= ov_next;
            go_reg <= go_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        d_reg <= d_next;
        dist_reg <= dist_next;
        stat_reg <= stat_next;
    end
endmodule

FILE: rtl/euclidean_distance_f32_core.sv
// Euclidean distance of two float32 vectors streamed one element pair per request.
// A request is accepted when in_valid is high and in_stall is low. Each element
//   pair with finite inputs takes the back end through subtract, square and add
//   on the shared float unit, stopping early on a non-finite partial result. The
//   last request of a vector runs the 32-step square root, unless an input was
//   not finite, before out_valid rises.
// A small queue lets the front keep taking requests while the back works.
// A result (distance, status) is offered on out_valid until out_stall is low;
//   while it waits, the next vector is already being accumulated.
// no_element requests change nothing; with last set they close the vector.
// Reset clears the sum to +0.0, the bad-input flag and all valids.
// Depends on edf32_pkg, edf32_queue, edf32_back.
module euclidean_distance_f32_core #(
    parameter int unsigned QUEUE_DEPTH = edf32_pkg::QueueDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] elem_a,
    input  logic [31:0] elem_b,
    input  logic        no_element,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] distance,
    output logic        status
);
    import edf32_pkg::*;

    item_t in_item, head;
    logic  full, empty, pop;

    assign in_item = '{a: elem_a, b: elem_b, no_element: no_element, last: last};
    assign in_stall = full;

    edf32_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(in_valid && !full), .push_item(in_item),
        .full(full), .pop(pop), .empty(empty), .head(head)
    );

    edf32_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(empty), .q_head(head), .q_pop(pop),
        .valid(out_valid), .stall(out_stall), .distance(distance), .status(status)
    );
endmodule

FILE: rtl/edf32_checker.sv
// Port-level checks of the distance core, bound to its top level.
// Depends on euclidean_distance_f32_core_defines.svh.
`include "euclidean_distance_f32_core_defines.svh"
module edf32_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [31:0] elem_a,
    input logic [31:0] elem_b,
    input logic        no_element,
    input logic        last,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] distance,
    input logic        status
);
    logic        in_wait, out_wait;
    logic [65:0] in_req;
    logic [32:0] out_res;

    assign in_wait = in_valid && in_stall;
    assign out_wait = out_valid && out_stall;
    assign in_req = {elem_a, elem_b, no_element, last};
    assign out_res = {distance, status};

    `ED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_res))
    `ED_ASSERT_IMPL(a_nan_fail, clk, rst_n, out_valid && distance[30:23] == 8'hFF, status)
    `ED_ASSERT_IMPL(a_sign_pos, clk, rst_n, out_valid && distance[31], status)
    `ED_ASSERT_NEXT(a_in_hold, clk, rst_n, in_wait, in_valid && $stable(in_req))
endmodule

bind euclidean_distance_f32_core edf32_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .elem_a(elem_a), .elem_b(elem_b), .no_element(no_element), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .distance(distance), .status(status)
);

FILE: verif/euclidean_distance_f32_core_tb.sv
// Self-checking bench for euclidean_distance_f32_core: streams float32 element pairs,
// predicts each distance and status with a bit-exact float model and compares results.
// Depends on edf32_pkg and the core RTL.
module euclidean_distance_f32_core_tb;
    import edf32_pkg::*;

    localparam logic [31:0] SignBit = 32'h80000000;
    localparam logic [31:0] MagMask = 32'h7FFFFFFF;
    localparam int CycleLimit = 400000;
    localparam int RandomItems = 800;

    typedef struct {
        logic [31:0] dist_bits;
        logic        stat;
    } distance_t;

    class distance_scoreboard;
        logic [31:0] sum_sq;
        bit          bad_seen;
        distance_t   pending_distances[$];
        int          errors;
        int          checked;

        function new();
            sum_sq = PosZero;
            bad_seen = 0;
            errors = 0;
            checked = 0;
        endfunction

        function int msb_pos(logic [63:0] v);
            for (int i = 63; i >= 0; i--)
                if (v[i]) return i;
            return -1;
        endfunction

        function void unpack(input logic [31:0] x, output int e, output logic [63:0] s);
            if (x[30:23] == 8'h00)
            begin
                s = {41'd0, x[22:0]};
                e = -149;
            end
            else
            begin
                s = {40'd0, 1'b1, x[22:0]};
                e = int'(x[30:23]) - 150;
            end
        endfunction

        // Rounds sign * sig * 2^e to single precision, nearest even.
        function logic [31:0] pack_round(logic [31:0] sign, int e, logic [63:0] sig);
            int p;
            int sh;
            int q;
            int be;
            logic [63:0] m;
            logic [63:0] rem;
            logic [63:0] half;
            p = msb_pos(sig);
            sh = p - 23;
            if (-149 - e > sh) sh = -149 - e;
            if (sh <= 0)
                m = sig << (-sh);
            else if (sh >= 64)
                m = (sh == 64 && sig > 64'h8000000000000000) ? 64'd1 : 64'd0;
            else
            begin
                rem = sig & ((64'd1 << sh) - 64'd1);
                half = 64'd1 << (sh - 1);
                m = sig >> sh;
                if (rem > half || (rem == half && m[0])) m++;
            end
            q = e + sh;
            if (m == (64'd1 << 24))
            begin
                m = m >> 1;
                q++;
            end
            if (m >= (64'd1 << 23))
            begin
                be = q + 150;
                if (be >= 255) return sign | PosInf;
                return sign | {1'b0, be[7:0], m[22:0]};
            end
            return sign | m[31:0];
        endfunction

        function logic [31:0] add_f32(logic [31:0] x, logic [31:0] y);
            logic [31:0] t;
            int eb;
            int es;
            int diff;
            int k;
            logic [63:0] mb;
            logic [63:0] ms;
            logic [63:0] r;
            if ((x & MagMask) == 0 && (y & MagMask) == 0) return x & y & SignBit;
            if ((x & MagMask) == 0) return y;
            if ((y & MagMask) == 0) return x;
            if ((y & MagMask) > (x & MagMask))
            begin
                t = x;
                x = y;
                y = t;
            end
            unpack(x, eb, mb);
            unpack(y, es, ms);
            diff = eb - es;
            mb = mb << 38;
            eb -= 38;
            if (diff <= 38)
                ms = ms << (38 - diff);
            else
            begin
                k = diff - 38;
                if (k >= 64) ms = 64'd1;
                else ms = (ms >> k) | 64'((ms & ((64'd1 << k) - 64'd1)) != 0);
            end
            if (((x ^ y) & SignBit) == 0)
                r = mb + ms;
            else
            begin
                r = mb - ms;
                if (r == 0) return PosZero;
            end
            return pack_round(x & SignBit, eb, r);
        endfunction

        function logic [31:0] mul_f32(logic [31:0] x, logic [31:0] y);
            int ex;
            int ey;
            logic [63:0] mx;
            logic [63:0] my;
            logic [31:0] sign;
            sign = (x ^ y) & SignBit;
            if ((x & MagMask) == 0 || (y & MagMask) == 0) return sign;
            unpack(x, ex, mx);
            unpack(y, ey, my);
            return pack_round(sign, ex + ey, mx * my);
        endfunction

        function logic [31:0] sqrt_f32(logic [31:0] x);
            int e;
            int t;
            logic [63:0] s;
            logic [63:0] res;
            logic [63:0] bitv;
            if ((x & MagMask) == 0 || not_finite(x)) return x;
            unpack(x, e, s);
            if ((e & 1) != 0)
            begin
                s = s << 1;
                e -= 1;
            end
            t = (60 - msb_pos(s)) & ~1;
            s = s << t;
            e -= t;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > s) bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (s >= res + bitv)
                begin
                    s = s - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            if (s != 0) res[0] = 1'b1;
            return pack_round(PosZero, e / 2, res);
        endfunction

        function void note_request(logic [31:0] a, logic [31:0] b, logic ne, logic lst);
            logic [31:0] d;
            logic [31:0] sq;
            distance_t r;
            if (!ne)
            begin
                if (not_finite(a) || not_finite(b))
                    bad_seen = 1;
                else if (!bad_seen)
                begin
                    d = add_f32(a, b ^ SignBit);
                    sq = not_finite(d) ? PosInf : mul_f32(d, d);
                    if (not_finite(sum_sq) || not_finite(sq)) sum_sq = PosInf;
                    else sum_sq = add_f32(sum_sq, sq);
                end
            end
            if (!lst) return;
            if (bad_seen)
            begin
                r.dist_bits = PosZero;
                r.stat = 1'b1;
            end
            else
            begin
                r.dist_bits = sqrt_f32(sum_sq);
                r.stat = not_finite(r.dist_bits);
            end
            pending_distances.push_back(r);
            sum_sq = PosZero;
            bad_seen = 0;
        endfunction

        function void check_result(logic [31:0] dist_bits, logic stat);
            distance_t e;
            checked++;
            if (pending_distances.size() == 0)
            begin
                errors++;
                if (errors < 40)
                    $display("%0t: unexpected result distance=%h status=%b", $time,
                             dist_bits, stat);
                return;
            end
            e = pending_distances.pop_front();
            if (dist_bits !== e.dist_bits)
            begin
                errors++;
                if (errors < 40)
                    $display("%0t: distance expected %h actual %h", $time, e.dist_bits,
                             dist_bits);
            end
            if (stat !== e.stat)
            begin
                errors++;
                if (errors < 40)
                    $display("%0t: status expected %b actual %b", $time, e.stat, stat);
            end
        endfunction

        function int pending();
            return pending_distances.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] elem_a = '0;
    logic [31:0] elem_b = '0;
    logic        no_element = 1'b0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] distance;
    logic        status;

    distance_scoreboard sb = new();
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit hold_armed = 0;
    int hold_left = 0;
    int cycles = 0;
    int sent = 0;
    int vectors = 0;

    euclidean_distance_f32_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .elem_a(elem_a), .elem_b(elem_b), .no_element(no_element), .last(last),
        .out_valid(out_valid), .out_stall(out_stall),
        .distance(distance), .status(status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The receiver owns its hold-off counter; the main flow only arms it once.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_armed)
        begin
            hold_armed = 0;
            hold_left <= 400;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(distance, status);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] pick_float();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 39))
            0: v = {v[31], 31'd0};
            1: v = {v[31], 8'h00, v[22:0]};
            2: v = {v[31], 31'h7F7FFFFF};
            3: v = {v[31], 8'hFF, 23'd0};
            4: v = {v[31], 8'hFF, v[22:1], 1'b1};
            5, 6: ;
            7: v = {v[31], 8'($urandom_range(190, 254)), v[22:0]};
            8: v = {v[31], 8'($urandom_range(1, 40)), v[22:0]};
            default: v = {v[31], 8'($urandom_range(110, 140)), v[22:0]};
        endcase
        return v;
    endfunction

    task automatic send_request(logic [31:0] a, logic [31:0] b, logic ne, logic lst);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        elem_a <= a;
        elem_b <= b;
        no_element <= ne;
        last <= lst;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(a, b, ne, lst);
        sent++;
        if (lst) vectors++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic send_random_vector();
        int len;
        logic [31:0] a;
        logic [31:0] b;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6);
        if (len == 0)
        begin
            send_request($urandom(), $urandom(), 1'b1, 1'b1);
            return;
        end
        for (int i = 0; i < len; i++)
        begin
            a = pick_float();
            b = ($urandom_range(0, 7) == 0) ? a : pick_float();
            if (i == len - 1)
                send_request(a, b, ($urandom_range(0, 7) == 0), 1'b1);
            else
                send_request(a, b, ($urandom_range(0, 9) == 0), 1'b0);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty vector, then zero and signed-zero pairs.
        send_request(32'h0, 32'h0, 1'b1, 1'b1);
        send_request(32'h00000000, 32'h80000000, 1'b0, 1'b1);
        send_request(32'h3F800000, 32'h00000000, 1'b0, 1'b0);
        send_request(32'h40000000, 32'hC0400000, 1'b0, 1'b1);
        // An item without element in the middle, then one closing the vector.
        send_request(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b0);
        send_request(32'h40400000, 32'h3F800000, 1'b0, 1'b0);
        send_request(32'h12345678, 32'h87654321, 1'b1, 1'b1);
        // Difference overflows, then large squares and their sum, which stay finite.
        send_request(32'h7F7FFFFF, 32'hFF7FFFFF, 1'b0, 1'b1);
        send_request(32'h5F000000, 32'h00000000, 1'b0, 1'b1);
        send_request(32'h5F000000, 32'h00000000, 1'b0, 1'b0);
        send_request(32'h5F000000, 32'h00000000, 1'b0, 1'b0);
        send_request(32'h5F000000, 32'h00000000, 1'b0, 1'b1);
        // Subnormal differences and exact cancellation.
        send_request(32'h00000001, 32'h80000001, 1'b0, 1'b0);
        send_request(32'h807FFFFF, 32'h00400000, 1'b0, 1'b0);
        send_request(32'h3FC00000, 32'h3FC00000, 1'b0, 1'b1);
        // Non-finite elements stop accumulation for the rest of the vector.
        send_request(32'h3F800000, 32'h40000000, 1'b0, 1'b0);
        send_request(32'h7F800000, 32'h3F800000, 1'b0, 1'b0);
        send_request(32'h3F800000, 32'h40000000, 1'b0, 1'b1);
        send_request(32'h3F800000, 32'hFFC00001, 1'b0, 1'b1);
        send_request(32'hFF800000, 32'h7F800000, 1'b0, 1'b1);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 71 : 0;
            rx_stall_pct = (phase == 0) ? 71 : (phase == 1) ? 6 : 0;
            if (phase == 2) hold_armed = 1;
            while (sent < 20 + (phase + 1) * (RandomItems / 3))
                send_random_vector();
            drain();
        end

        $display("Sent %0d requests in %0d vectors, checked %0d distances", sent, vectors,
                 sb.checked);
        $display("Covered zeros, subnormals, overflow, non-finite inputs and empty vectors");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
